>>> src/mp2_pkg.sv
package mp2_pkg;

  localparam int ENTRY_W   = 32;
  localparam int EXP_W     = 32;
  // the sign bit is never scanned, so the top bit looked at is one below it
  localparam int LAST_BIT  = EXP_W - 2;
  localparam int BIT_CNT_W = $clog2(LAST_BIT + 1);

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [EXP_W-1:0]   exp_t;
  typedef logic [BIT_CNT_W-1:0]      bit_cnt_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture base and exponent, accumulator to identity
    logic mul;       // register the partial products
    logic use_base;  // right-hand operand is the base, else the accumulator
    logic add;       // sum the partial products into the accumulator
    logic shift;     // move on to the next exponent bit
    logic publish;   // copy the accumulator into the output register
  } mp2_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic nonpos;    // exponent is zero or negative
    logic exp_bit;   // exponent bit under scan
    logic out_free;  // output register can take a result this cycle
  } mp2_status_t;

endpackage

>>> src/mp2_in_if.sv
interface mp2_in_if import mp2_pkg::*;;
  logic   valid;
  logic   ready;
  entry_t entry_00;
  entry_t entry_01;
  entry_t entry_10;
  entry_t entry_11;
  exp_t   exponent;

  modport source (
    output valid, entry_00, entry_01, entry_10, entry_11, exponent,
    input  ready
  );
  modport sink (
    input  valid, entry_00, entry_01, entry_10, entry_11, exponent,
    output ready
  );
endinterface

>>> src/mp2_out_if.sv
interface mp2_out_if import mp2_pkg::*;;
  logic   valid;
  logic   ready;
  entry_t power_00;
  entry_t power_01;
  entry_t power_10;
  entry_t power_11;

  modport source (
    output valid, power_00, power_01, power_10, power_11,
    input  ready
  );
  modport sink (
    input  valid, power_00, power_01, power_10, power_11,
    output ready
  );
endinterface

>>> src/mp2_ctrl.sv
module mp2_ctrl import mp2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  mp2_status_t status,
  output mp2_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE, START, SQ_MUL, SQ_ADD, BM_MUL, BM_ADD, FINISH
  } state_t;

  state_t   state;
  bit_cnt_t cnt;
  logic     last_bit;

  // held low through reset so that no beat is taken and then dropped
  assign in_ready = (state == IDLE) && !rst;
  assign last_bit = (cnt == '0);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE:   cmd.load = in_valid;
      START:  ;
      SQ_MUL: cmd.mul = 1'b1;
      SQ_ADD: begin
        cmd.add   = 1'b1;
        cmd.shift = !status.exp_bit;
      end
      BM_MUL: begin
        cmd.mul      = 1'b1;
        cmd.use_base = 1'b1;
      end
      BM_ADD: begin
        cmd.add   = 1'b1;
        cmd.shift = 1'b1;
      end
      FINISH: cmd.publish = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= START;
            cnt   <= bit_cnt_t'(LAST_BIT);
          end
        end
        START: state <= status.nonpos ? FINISH : SQ_MUL;
        SQ_MUL: state <= SQ_ADD;
        SQ_ADD: begin
          if (status.exp_bit) begin
            state <= BM_MUL;
          end else if (last_bit) begin
            state <= FINISH;
          end else begin
            state <= SQ_MUL;
            cnt   <= cnt - 1'b1;
          end
        end
        BM_MUL: state <= BM_ADD;
        BM_ADD: begin
          if (last_bit) begin
            state <= FINISH;
          end else begin
            state <= SQ_MUL;
            cnt   <= cnt - 1'b1;
          end
        end
        FINISH: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> src/mp2_datapath.sv
module mp2_datapath import mp2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      entry_00,
  input  entry_t      entry_01,
  input  entry_t      entry_10,
  input  entry_t      entry_11,
  input  exp_t        exponent,
  input  mp2_cmd_t    cmd,
  output mp2_status_t status,
  mp2_out_if.source   result
);

  entry_t base [2][2];
  entry_t acc  [2][2];
  entry_t rhs  [2][2];
  entry_t prod_a [2][2];
  entry_t prod_b [2][2];
  exp_t   exp_sh;
  logic   nonpos;
  logic   out_valid;
  entry_t out_m [2][2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        rhs[i][j] = cmd.use_base ? base[i][j] : acc[i][j];
      end
    end
  end

  // one lane per result entry, two multipliers per lane
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base[0][0] <= entry_00;
      base[0][1] <= entry_01;
      base[1][0] <= entry_10;
      base[1][1] <= entry_11;
      exp_sh     <= exponent;
      nonpos     <= (exponent == '0) || exponent[EXP_W-1];
    end else if (cmd.shift) begin
      exp_sh <= exp_sh << 1;
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (cmd.load) begin
          acc[i][j] <= (i == j) ? entry_t'(1) : '0;
        end else if (cmd.add) begin
          acc[i][j] <= prod_a[i][j] + prod_b[i][j];
        end
        if (cmd.mul) begin
          prod_a[i][j] <= acc[i][0] * rhs[0][j];
          prod_b[i][j] <= acc[i][1] * rhs[1][j];
        end
        if (cmd.publish) begin
          out_m[i][j] <= acc[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid    = out_valid;
  assign result.power_00 = out_m[0][0];
  assign result.power_01 = out_m[0][1];
  assign result.power_10 = out_m[1][0];
  assign result.power_11 = out_m[1][1];

  assign status.nonpos   = nonpos;
  assign status.exp_bit  = exp_sh[LAST_BIT];
  assign status.out_free = !out_valid || result.ready;

endmodule

>>> src/matrix_power_2x2_unit.sv
// 2x2 matrix power by square-and-multiply. a beat on feed carries four
// signed 32-bit entries and a signed exponent; one beat on result carries the
// base raised to that power, every product and sum wrapping modulo 2^32. an
// exponent of zero or below returns the identity. exponent bits 30 down to 0
// are scanned msb first: each bit costs a squaring and, when the bit is set,
// a multiply by the base. each matrix multiply runs through four lanes (two
// registered 32x32 multipliers each, then an add). one item is in flight at a
// time; feed is ready again as soon as a result has moved into the output
// register, so the next item can start while that result waits to be taken.
module matrix_power_2x2_unit import mp2_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mp2_in_if.sink    feed,
  mp2_out_if.source result
);

  mp2_cmd_t    cmd;
  mp2_status_t status;

  // sequencer: bit counter and state machine
  mp2_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (feed.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // matrices, product lanes, exponent shifter and output register
  mp2_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .entry_00 (feed.entry_00),
    .entry_01 (feed.entry_01),
    .entry_10 (feed.entry_10),
    .entry_11 (feed.entry_11),
    .exponent (feed.exponent),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

>>> src/mp2_checker.sv
module mp2_checker import mp2_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input entry_t power_00,
  input entry_t power_11
);

  // one item in flight: no accept straight after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("feed ready straight after an accepted beat");

  // a new result only appears as the sequencer leaves its busy states
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while feed was idle");

  a_out_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(power_00) && $stable(power_11))
    else $error("stalled result changed");

endmodule

bind matrix_power_2x2_unit mp2_checker u_mp2_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (feed.valid),
  .in_ready  (feed.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .power_00  (result.power_00),
  .power_11  (result.power_11)
);

>>> bench/matrix_power_2x2_unit_tb.sv
`timescale 1ns / 100ps

module matrix_power_2x2_unit_tb;
  import mp2_pkg::*;

  // a 2x2 matrix as four lanes: [0] row 0 col 0, [1] row 0 col 1,
  // [2] row 1 col 0, [3] row 1 col 1
  typedef logic [3:0][ENTRY_W-1:0] mat_t;

  typedef struct packed {
    mat_t base;
    exp_t exponent;
  } feed_beat_t;

  localparam mat_t IDENTITY = {32'd1, 32'd0, 32'd0, 32'd1};

  // fixed bounds on run length, in clock cycles
  localparam int LONG_HOLD_CYCLES = 400;  // receiver stall long enough to fill the block
  localparam int TAIL_CYCLES      = 140;  // a little more than the slowest item takes
  localparam int RANDOM_PER_PHASE = 360;

  localparam logic [ENTRY_W-1:0] MIN_ENTRY = 32'h8000_0000;
  localparam logic [ENTRY_W-1:0] MAX_ENTRY = 32'h7fff_ffff;

  logic clk;
  logic rst;

  mp2_in_if  feed_bus ();
  mp2_out_if result_bus ();

  matrix_power_2x2_unit dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_bus),
    .result (result_bus)
  );

  // items waiting to be offered, and powers waiting to come out
  feed_beat_t pending_feed[$];
  mat_t       expected_power[$];

  // idling, in percent of cycles; only the stimulus process writes these
  int sender_idle_pct = 6;
  int sink_idle_pct   = 62;

  // long receiver stall: requested by the stimulus, carried out by the sink
  bit long_hold_due  = 0;
  bit long_hold_done = 0;
  int hold_left      = 0;

  int mismatch_count = 0;
  int accepted_count = 0;
  int nonpos_count   = 0;
  int checked_count  = 0;

  // ---------------------------------------------------------------------------
  // predictor: square-and-multiply with every lane wrapping modulo 2^32
  // ---------------------------------------------------------------------------

  // products and sums are kept at lane width, so the truncation does the wrap
  function automatic mat_t mat_product(mat_t x, mat_t y);
    mat_t p;
    p[0] = x[0] * y[0] + x[1] * y[2];
    p[1] = x[0] * y[1] + x[1] * y[3];
    p[2] = x[2] * y[0] + x[3] * y[2];
    p[3] = x[2] * y[1] + x[3] * y[3];
    return p;
  endfunction

  function automatic mat_t matrix_power(mat_t base, exp_t e);
    mat_t acc;
    acc = IDENTITY;
    // zero or negative exponent leaves the identity untouched
    if (e > 0) begin
      // the sign bit is known clear here, so the scan starts one below it
      for (int b = EXP_W - 2; b >= 0; b--) begin
        acc = mat_product(acc, acc);
        if (e[b])
          acc = mat_product(acc, base);
      end
    end
    return acc;
  endfunction

  // ---------------------------------------------------------------------------
  // random content
  // ---------------------------------------------------------------------------

  function automatic logic [ENTRY_W-1:0] rand_entry();
    case ($urandom_range(9))
      0, 1: return 32'($signed($urandom_range(8)) - 4);  // small, both signs
      2: begin
        case ($urandom_range(4))
          0: return MIN_ENTRY;
          1: return MAX_ENTRY;
          2: return '1;
          3: return '0;
          default: return 32'd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic exp_t rand_exponent();
    case ($urandom_range(19))
      0: return '0;
      1: return exp_t'($urandom | 32'h8000_0000);  // negative, any size
      2: return exp_t'(1);
      3: return exp_t'(MAX_ENTRY);                 // every scanned bit set
      4, 5: return exp_t'($urandom >> 1);          // any non-negative value
      default: return exp_t'($urandom_range(64, 2));
    endcase
  endfunction

  task automatic queue_item(logic [ENTRY_W-1:0] a00, logic [ENTRY_W-1:0] a01,
                            logic [ENTRY_W-1:0] a10, logic [ENTRY_W-1:0] a11,
                            exp_t e);
    feed_beat_t beat;
    beat.base     = {a11, a10, a01, a00};
    beat.exponent = e;
    pending_feed.push_back(beat);
  endtask

  task automatic queue_random(int count);
    repeat (count)
      queue_item(rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_exponent());
  endtask

  // the sender holds back until the block has handed over every power
  task automatic wait_drained();
    while (pending_feed.size() != 0 || feed_bus.valid || expected_power.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // feed driver: offers the head of pending_feed, predicts on every accepted beat
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    feed_beat_t beat;
    if (rst) begin
      feed_bus.valid <= 1'b0;
    end else begin
      if (feed_bus.valid && feed_bus.ready) begin
        expected_power.push_back(matrix_power(
          {feed_bus.entry_11, feed_bus.entry_10, feed_bus.entry_01, feed_bus.entry_00},
          feed_bus.exponent));
        accepted_count++;
        if (feed_bus.exponent <= 0)
          nonpos_count++;
      end
      // a beat still waiting for ready must stay put
      if (!feed_bus.valid || feed_bus.ready) begin
        if (pending_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          beat = pending_feed.pop_front();
          feed_bus.valid    <= 1'b1;
          feed_bus.entry_00 <= beat.base[0];
          feed_bus.entry_01 <= beat.base[1];
          feed_bus.entry_10 <= beat.base[2];
          feed_bus.entry_11 <= beat.base[3];
          feed_bus.exponent <= beat.exponent;
        end else begin
          feed_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random back-pressure plus one long stall on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (long_hold_due && !long_hold_done) begin
      long_hold_done   <= 1'b1;
      hold_left        <= LONG_HOLD_CYCLES - 1;
      result_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left        <= hold_left - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each power taken is checked lane by lane against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    mat_t got;
    mat_t want;
    string lane_name[4];
    lane_name = '{"power_00", "power_01", "power_10", "power_11"};
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = {result_bus.power_11, result_bus.power_10, result_bus.power_01,
             result_bus.power_00};
      if (expected_power.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", got));
      end else begin
        want = expected_power.pop_front();
        checked_count++;
        for (int i = 0; i < 4; i++)
          if (got[i] !== want[i])
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      checked_count, lane_name[i], got[i], want[i]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int mark;
    // known levels on every input before the first edge
    rst                 = 1'b1;
    feed_bus.valid      = 1'b0;
    feed_bus.entry_00   = '0;
    feed_bus.entry_01   = '0;
    feed_bus.entry_10   = '0;
    feed_bus.entry_11   = '0;
    feed_bus.exponent   = '0;
    result_bus.ready    = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: identity for zero and negative exponents, base for one,
    // lane extremes, wrap-around and the longest scan
    queue_item(32'd3, 32'd5, 32'd7, 32'd11, exp_t'(0));
    queue_item(32'd3, 32'd5, 32'd7, 32'd11, exp_t'(-1));
    queue_item(MAX_ENTRY, MIN_ENTRY, '1, 32'd2, exp_t'(MIN_ENTRY));
    queue_item(MIN_ENTRY, MAX_ENTRY, 32'hdead_beef, '1, exp_t'(1));
    queue_item(MAX_ENTRY, MAX_ENTRY, MAX_ENTRY, MAX_ENTRY, exp_t'(1));
    queue_item(MIN_ENTRY, MIN_ENTRY, MIN_ENTRY, MIN_ENTRY, exp_t'(2));
    queue_item('1, '1, '1, '1, exp_t'(3));
    queue_item('0, '0, '0, '0, exp_t'(5));
    queue_item('0, '0, '0, '0, exp_t'(0));
    // fibonacci matrix: small power stays exact, larger ones wrap
    queue_item(32'd1, 32'd1, 32'd1, 32'd0, exp_t'(10));
    queue_item(32'd1, 32'd1, 32'd1, 32'd0, exp_t'(46));
    queue_item(32'd1, 32'd1, 32'd1, 32'd0, exp_t'(47));
    queue_item(32'd1, 32'd1, 32'd1, 32'd0, exp_t'(MAX_ENTRY));
    queue_item(32'd2, 32'd0, 32'd0, '1, exp_t'(31));
    queue_item(32'd2, 32'd0, 32'd0, '1, exp_t'(32));
    queue_item(32'd1, 32'd0, 32'd0, 32'd1, exp_t'(32'h5555_5555));
    queue_item(MAX_ENTRY, 32'd1, MIN_ENTRY, '1, exp_t'(32'h4000_0000));
    queue_item(32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 32'h8765_4321,
               exp_t'(MAX_ENTRY));

    // phase one: sender mostly busy, receiver often stalling
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    // phase two: the other way round
    sender_idle_pct = 62;
    sink_idle_pct   = 6;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    // phase three: no idling, with one long receiver stall part-way through
    // so that the output register and the working item both back up
    sender_idle_pct = 0;
    sink_idle_pct   = 0;
    queue_random(RANDOM_PER_PHASE);
    mark = accepted_count + 40;
    while (accepted_count < mark)
      @(posedge clk);
    long_hold_due = 1'b1;
    wait_drained();

    // let any stray beat show itself
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d matrix beats, %0d with a non-positive exponent, under three",
             accepted_count, nonpos_count);
    $display("idling mixes and a %0d-cycle receiver stall; %0d powers checked",
             LONG_HOLD_CYCLES, checked_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("timeout: %0d beats in flight", expected_power.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> matrix_power_2x2_unit.f
src/mp2_pkg.sv
src/mp2_in_if.sv
src/mp2_out_if.sv
src/mp2_ctrl.sv
src/mp2_datapath.sv
src/matrix_power_2x2_unit.sv
src/mp2_checker.sv
bench/matrix_power_2x2_unit_tb.sv
